// ===== src/ldf_pkg.sv =====
package ldf_pkg;

    // packet length in bytes, header and footer included
    localparam int unsigned PACKET_BYTES_DEF = 12;
    localparam int unsigned PACKET_BYTES_MIN = 12;
    localparam int unsigned PACKET_BYTES_MAX = 31;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OUT_DATA_W = 80;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'h55;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 2'd1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FOOTER = 2'd1,
        ST_BAD_CHECK  = 2'd2,
        ST_BAD_ID     = 2'd3
    } ldf_status_t;

    typedef struct packed {
        logic [31:0] timestamp_ms;
        logic [15:0] angle_tenths;
        logic [15:0] distance_mm;
        logic [7:0]  sensor_id;
        ldf_status_t status;
    } ldf_result_t;

    typedef struct packed {
        logic at_last;     // next accepted word closes a packet
        logic collecting;  // header seen, packet in progress
    } ldf_ctl_t;

endpackage

// ===== src/ldf_collector.sv =====
module ldf_collector
    import ldf_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] header_value,
    input  logic [BYTE_W-1:0] footer_value,
    output ldf_ctl_t          ctl,
    output logic              res_valid,
    output ldf_result_t       res
);

    localparam int unsigned POS_W = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] CHECK_POS = POS_W'(PACKET_BYTES - 2);
    localparam logic [POS_W-1:0] XOR_END   = POS_W'(PACKET_BYTES - 3);

    typedef enum logic [1:0] {
        S_HUNT    = 2'b01,
        S_COLLECT = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic [7:0]        id_reg, id_next;
    logic [15:0]       dist_reg, dist_next;
    logic [15:0]       angle_reg, angle_next;
    logic [31:0]       time_reg, time_next;
    logic              done;

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        check_next = check_reg;
        id_next    = id_reg;
        dist_next  = dist_reg;
        angle_next = angle_reg;
        time_next  = time_reg;
        done       = 1'b0;
        if (byte_valid) begin
            unique case (state_reg)
                S_HUNT: begin
                    if (rx_byte == header_value) begin
                        state_next = S_COLLECT;
                        pos_next   = POS_W'(1);
                        xor_next   = '0;
                    end
                end
                S_COLLECT: begin
                    if (pos_reg <= XOR_END)
                        xor_next = xor_reg ^ rx_byte;
                    if (pos_reg == POS_W'(1)) id_next          = rx_byte;
                    if (pos_reg == POS_W'(2)) dist_next[7:0]   = rx_byte;
                    if (pos_reg == POS_W'(3)) dist_next[15:8]  = rx_byte;
                    if (pos_reg == POS_W'(4)) angle_next[7:0]  = rx_byte;
                    if (pos_reg == POS_W'(5)) angle_next[15:8] = rx_byte;
                    if (pos_reg == POS_W'(6)) time_next[7:0]   = rx_byte;
                    if (pos_reg == POS_W'(7)) time_next[15:8]  = rx_byte;
                    if (pos_reg == POS_W'(8)) time_next[23:16] = rx_byte;
                    if (pos_reg == POS_W'(9)) time_next[31:24] = rx_byte;
                    if (pos_reg == CHECK_POS)
                        check_next = rx_byte;
                    if (pos_reg == LAST_POS) begin
                        done       = 1'b1;
                        state_next = S_HUNT;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                default: state_next = S_HUNT;
            endcase
        end
    end

    // status priority: footer, then checksum, then sensor id range
    always_comb begin
        res.sensor_id    = id_reg;
        res.distance_mm  = dist_reg;
        res.angle_tenths = angle_reg;
        res.timestamp_ms = time_reg;
        priority if (rx_byte != footer_value) res.status = ST_BAD_FOOTER;
        else if (xor_reg != check_reg)        res.status = ST_BAD_CHECK;
        else if (id_reg >= 8'd2)              res.status = ST_BAD_ID;
        else                                  res.status = ST_OK;
    end

    assign res_valid      = done;
    assign ctl.collecting = (state_reg == S_COLLECT);
    assign ctl.at_last    = (state_reg == S_COLLECT) && (pos_reg == LAST_POS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_HUNT;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        xor_reg   <= xor_next;
        check_reg <= check_next;
        id_reg    <= id_next;
        dist_reg  <= dist_next;
        angle_reg <= angle_next;
        time_reg  <= time_next;
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("packet position beyond last byte");

    a_hunt_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_HUNT |-> pos_reg == '0)
        else $error("position not cleared while hunting");

    a_done_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> state_reg == S_HUNT && pos_reg == '0)
        else $error("collector did not return to hunting after a packet");

    a_header_start: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_valid && state_reg == S_HUNT && rx_byte == header_value
        |=> state_reg == S_COLLECT && pos_reg == POS_W'(1))
        else $error("header word did not open a packet");

endmodule

// ===== src/lidar_packet_deframer_unit.sv =====
// Lidar packet deframer.
// Input: one received serial byte per word on s_tvalid/s_tready/s_tdata.
// While hunting, words that differ from the header register are dropped;
// a header word opens a packet of PACKET_BYTES bytes, collected without
// resynchronizing. On the last byte one result word leaves on
// m_tvalid/m_tready/m_tdata with a status (ok, bad footer, bad checksum,
// sensor id out of range) and the decoded id, distance, angle and timestamp.
// Configuration: cfg_wr_en/cfg_wr_addr/cfg_wr_data write the header (index 0)
// and footer (index 1) bytes; other indexes are ignored.
// Throughput: one input word per cycle but for the stall below. The result is
// registered and shows on m_tvalid the cycle after the closing byte is accepted.
// Stall: while a result waits in the output register, bytes keep flowing;
// only the closing byte of the next packet is held off until the result
// is taken.
// Reset (aresetn low, synchronous): hunting, output empty, header 0xAA,
// footer 0x55.
module lidar_packet_deframer_unit
    import ldf_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] status, [9:2] sensor_id, [25:10] distance_mm,
    // [41:26] angle_tenths, [73:42] timestamp_ms, [79:74] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_addr,
    input  logic [BYTE_W-1:0]     cfg_wr_data
);

    localparam int unsigned RES_W = $bits(ldf_result_t);

    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] footer_reg;
    logic              out_valid_reg, out_valid_next;
    ldf_result_t       out_data_reg;
    ldf_ctl_t          ctl;
    logic              res_valid;
    ldf_result_t       res;
    logic              s_accept;

    // hold off only the closing byte while the output slot is still full
    assign s_tready = !(ctl.at_last && out_valid_reg && !m_tready);
    assign s_accept = s_tvalid && s_tready;

    ldf_collector #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_collector (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_valid   (s_accept),
        .rx_byte      (s_tdata),
        .header_value (header_reg),
        .footer_value (footer_reg),
        .ctl          (ctl),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            footer_reg <= FOOTER_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_wr_addr == REG_HEADER) header_reg <= cfg_wr_data;
            if (cfg_wr_addr == REG_FOOTER) footer_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_data_reg};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_valid && out_valid_reg && !m_tready))
        else $error("result overwrote a word still waiting on the output");

    a_result_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_tvalid)
        else $error("finished packet did not reach the output");

    a_ready_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> ctl.at_last && out_valid_reg)
        else $error("input stalled without a pending closing byte");

    a_last_in_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.at_last |-> ctl.collecting)
        else $error("closing position flagged while hunting");

endmodule

// ===== test/lidar_packet_deframer_unit_tb.sv =====
`timescale 1ns / 100ps

module lidar_packet_deframer_unit_tb;
    import ldf_pkg::*;

    localparam int PKT_LEN       = PACKET_BYTES_DEF;
    localparam int RES_W         = $bits(ldf_result_t);
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 240;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_addr = '0;
    logic [BYTE_W-1:0]     cfg_wr_data = '0;

    lidar_packet_deframer_unit #(
        .PACKET_BYTES(PKT_LEN)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_addr(cfg_wr_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    logic [7:0]  rx_bytes_queued[$];
    ldf_result_t packet_results_due[$];
    int          bytes_queued = 0;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          src_gap = 0;
    int          dst_gap = 0;
    bit          steady_flow = 1'b0;
    bit          s_took = 1'b0;

    // deframer mirror
    logic [7:0]  hdr_reg = HEADER_RESET;
    logic [7:0]  ftr_reg = FOOTER_RESET;
    bit          in_packet = 1'b0;
    int          pkt_pos = 0;
    logic [7:0]  run_xor = '0;
    logic [7:0]  check_byte = '0;
    logic [7:0]  got_id = '0;
    logic [15:0] got_dist = '0;
    logic [15:0] got_angle = '0;
    logic [31:0] got_stamp = '0;

    // stimulus side view of the registers
    logic [7:0]  gen_hdr = HEADER_RESET;
    logic [7:0]  gen_ftr = FOOTER_RESET;
    logic [7:0]  pkt_buf[PKT_LEN];

    task automatic deframe_byte(input logic [7:0] b);
        ldf_result_t r;
        if (!in_packet) begin
            if (b == hdr_reg) begin
                in_packet = 1'b1;
                pkt_pos = 1;
                run_xor = '0;
            end
        end else begin
            if (pkt_pos <= PKT_LEN - 3)
                run_xor = run_xor ^ b;
            case (pkt_pos)
                1: got_id = b;
                2: got_dist[7:0] = b;
                3: got_dist[15:8] = b;
                4: got_angle[7:0] = b;
                5: got_angle[15:8] = b;
                6: got_stamp[7:0] = b;
                7: got_stamp[15:8] = b;
                8: got_stamp[23:16] = b;
                9: got_stamp[31:24] = b;
                default: ;
            endcase
            if (pkt_pos == PKT_LEN - 2)
                check_byte = b;
            if (pkt_pos < PKT_LEN - 1) begin
                pkt_pos++;
            end else begin
                // footer beats checksum, checksum beats id range
                if (b != ftr_reg)
                    r.status = ST_BAD_FOOTER;
                else if (run_xor != check_byte)
                    r.status = ST_BAD_CHECK;
                else if (got_id >= 8'd2)
                    r.status = ST_BAD_ID;
                else
                    r.status = ST_OK;
                r.sensor_id = got_id;
                r.distance_mm = got_dist;
                r.angle_tenths = got_angle;
                r.timestamp_ms = got_stamp;
                packet_results_due.push_back(r);
                in_packet = 1'b0;
                pkt_pos = 0;
            end
        end
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        ldf_result_t got;
        ldf_result_t want;
        logic [OUT_DATA_W-RES_W-1:0] pad;
        got = word[RES_W-1:0];
        pad = word[OUT_DATA_W-1:RES_W];
        if (packet_results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result word %h", word);
        end else begin
            want = packet_results_due.pop_front();
            if (got.status !== want.status || got.sensor_id !== want.sensor_id ||
                got.distance_mm !== want.distance_mm ||
                got.angle_tenths !== want.angle_tenths ||
                got.timestamp_ms !== want.timestamp_ms || pad !== '0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result mismatch exp/got: status %0d/%0d id %h/%h",
                             want.status, got.status, want.sensor_id, got.sensor_id,
                             " dist %h/%h angle %h/%h",
                             want.distance_mm, got.distance_mm,
                             want.angle_tenths, got.angle_tenths,
                             " stamp %h/%h pad %h",
                             want.timestamp_ms, got.timestamp_ms, pad);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
            hdr_reg = HEADER_RESET;
            ftr_reg = FOOTER_RESET;
            in_packet = 1'b0;
            pkt_pos = 0;
            run_xor = '0;
            check_byte = '0;
            got_id = '0;
            got_dist = '0;
            got_angle = '0;
            got_stamp = '0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    REG_HEADER: hdr_reg = cfg_wr_data;
                    REG_FOOTER: ftr_reg = cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // source: hold the word until taken, then idle or advance
    always @(negedge aclk) begin
        if (!s_tvalid || s_took) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (!steady_flow && $urandom_range(0, 15) == 0) begin
                s_tvalid <= 1'b0;
                src_gap <= $urandom_range(0, 18);
            end else if (rx_bytes_queued.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= rx_bytes_queued.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink backpressure
    always @(negedge aclk) begin
        if (dst_gap > 0) begin
            m_tready <= 1'b0;
            dst_gap <= dst_gap - 1;
        end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            dst_gap <= $urandom_range(0, 18);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("lidar_packet_deframer_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_bytes_queued.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [31:0] pick_field(input int w);
        logic [31:0] mask;
        logic [31:0] v;
        mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = mask;
            2: v = 32'd1 << (w - 1);
            3: v = (32'd1 << (w - 1)) - 32'd1;
            default: v = $urandom();
        endcase
        return v & mask;
    endfunction

    task automatic build_packet(input logic [7:0] id, input logic [15:0] dist_val,
                                input logic [15:0] ang, input logic [31:0] stamp,
                                input bit bad_check, input bit bad_footer);
        logic [7:0] x;
        int k;
        x = '0;
        pkt_buf[0] = gen_hdr;
        pkt_buf[1] = id;
        pkt_buf[2] = dist_val[7:0];
        pkt_buf[3] = dist_val[15:8];
        pkt_buf[4] = ang[7:0];
        pkt_buf[5] = ang[15:8];
        pkt_buf[6] = stamp[7:0];
        pkt_buf[7] = stamp[15:8];
        pkt_buf[8] = stamp[23:16];
        pkt_buf[9] = stamp[31:24];
        for (k = 10; k <= PKT_LEN - 3; k++)
            pkt_buf[k] = 8'($urandom_range(0, 255));
        for (k = 1; k <= PKT_LEN - 3; k++)
            x = x ^ pkt_buf[k];
        pkt_buf[PKT_LEN-2] = bad_check ? (x ^ 8'($urandom_range(1, 255))) : x;
        pkt_buf[PKT_LEN-1] = bad_footer ? (gen_ftr ^ 8'($urandom_range(1, 255))) : gen_ftr;
    endtask

    task automatic queue_random_traffic(input int n_bytes);
        int start;
        int pick;
        int cut;
        int k;
        logic [7:0] b;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // raw noise, may hold a stray header
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end else begin
                build_packet(($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 1))
                                                         : 8'($urandom_range(0, 255)),
                             16'(pick_field(16)), 16'(pick_field(16)), pick_field(32),
                             $urandom_range(0, 6) == 0, $urandom_range(0, 6) == 0);
                // drop the tail of some packets so the next one lands inside
                cut = (pick < 16) ? $urandom_range(1, PKT_LEN - 1) : PKT_LEN;
                for (k = 0; k < cut; k++)
                    push_byte(pkt_buf[k]);
                if ($urandom_range(0, 3) == 0) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == gen_hdr)
                        b = ~b;
                    push_byte(b);
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        #1;
        if (idx == REG_HEADER)
            gen_hdr = val;
        else if (idx == REG_FOOTER)
            gen_ftr = val;
    endtask

    task automatic wait_idle;
        do begin
            @(posedge aclk);
            #1;
        end while (rx_bytes_queued.size() != 0 || s_tvalid ||
                   packet_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        #1;
    endtask

    initial begin
        int ph;
        int k;
        logic [7:0] hv;
        logic [7:0] fv;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        #1;

        // hunting drops, header byte as data, field extremes, footer priority
        push_byte(8'h00);
        push_byte(8'hFF);
        build_packet(8'h01, {8'h00, gen_hdr}, 16'h8000, 32'hFFFF_FFFF, 1'b0, 1'b0);
        for (k = 0; k < PKT_LEN; k++)
            push_byte(pkt_buf[k]);
        build_packet(8'hFF, 16'hFFFF, 16'h7FFF, 32'h0000_0000, 1'b1, 1'b1);
        for (k = 0; k < PKT_LEN; k++)
            push_byte(pkt_buf[k]);
        wait_idle();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    hv = 8'h00;
                    fv = 8'hFF;
                end
                1: begin
                    hv = 8'hFF;
                    fv = 8'h00;
                end
                4: begin
                    hv = HEADER_RESET;
                    fv = FOOTER_RESET;
                end
                default: begin
                    hv = 8'($urandom_range(0, 255));
                    fv = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(REG_HEADER, hv);
            write_reg(REG_FOOTER, fv);
            if (ph == 2) begin
                write_reg(REG_SPARE_2, 8'($urandom_range(0, 255)));
                write_reg(REG_SPARE_3, 8'($urandom_range(0, 255)));
            end
            if (ph == 4)
                steady_flow = 1'b1;
            queue_random_traffic(PHASE_BYTES);

            if (ph == 1) begin
                // close any open packet, then rewrite both registers mid-packet
                repeat (PKT_LEN - 1) push_byte(~gen_hdr);
                build_packet(8'h01, 16'(pick_field(16)), 16'(pick_field(16)),
                             pick_field(32), 1'b0, 1'b0);
                for (k = 0; k < PKT_LEN / 2; k++)
                    push_byte(pkt_buf[k]);
                wait_idle();
                write_reg(REG_FOOTER, ~gen_ftr);
                write_reg(REG_HEADER, pkt_buf[PKT_LEN/2]);
                pkt_buf[PKT_LEN-1] = gen_ftr;
                for (k = PKT_LEN / 2; k < PKT_LEN; k++)
                    push_byte(pkt_buf[k]);
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("lidar_packet_deframer_unit regression: pass");
        else
            $display("lidar_packet_deframer_unit regression: fail");
        $finish;
    end

endmodule
